@@ hdl/rtri_pkg.sv @@
// shared widths, register map and constants for the ray/triangle intersection block
`timescale 1ns / 1ps

package rtri_pkg;

  // coordinate width (Q8.8 at 16 bits)
  localparam int COORD_WIDTH = 16;

  // edge and origin-offset components
  localparam int EW     = COORD_WIDTH + 1;
  // normal components, edge cross edge
  localparam int NW     = 2 * EW + 1;
  // origin offset cross direction
  localparam int DAO_W  = EW + COORD_WIDTH + 1;
  // dot product sums, widest case is offset . normal
  localparam int ACC_W  = EW + NW + 2;

  // threshold register and its compare width
  localparam int THR_W  = 40;
  localparam int CMP_W  = (ACC_W > THR_W) ? ACC_W : THR_W;

  // quotient layout: Q16.16, 31 magnitude bits
  localparam int FRAC_W = 16;
  localparam int Q_W    = 31;
  localparam int NUM_W  = ACC_W - 1 + FRAC_W;
  localparam int TOP_W  = NUM_W - Q_W;

  // configuration port
  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [IDX_W-1:0] REG_DET_THR  = 3'd6;

  localparam logic [THR_W-1:0] DET_THR_RESET = 40'd17;
  localparam logic [31:0]      DIST_SAT      = 32'h7FFF_FFFF;

endpackage

@@ hdl/rtri_div.sv @@
// pipelined restoring divider for the hit distance, one quotient bit per stage
`timescale 1ns / 1ps

module rtri_div
  import rtri_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic               in_hit,
  input  logic [NUM_W-1:0]   in_num,
  input  logic [ACC_W-2:0]   in_det,
  output logic               out_valid,
  output logic               out_hit,
  output logic [31:0]        out_distance
);

  logic              v   [Q_W+1];
  logic              h   [Q_W+1];
  logic              sat [Q_W+1];
  logic [ACC_W-2:0]  r   [Q_W+1];
  logic [ACC_W-2:0]  d   [Q_W+1];
  logic [Q_W-1:0]    lo  [Q_W+1];
  logic [Q_W-1:0]    q   [Q_W+1];

  logic [TOP_W-1:0]  top;
  logic              top_ge;

  // upper numerator bits against det decide saturation
  assign top    = in_num[NUM_W-1:Q_W];
  assign top_ge = (ACC_W'(top) >= ACC_W'(in_det));

  // first stage: saturation check and initial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      h[0]   <= in_hit;
      sat[0] <= top_ge;
      r[0]   <= (ACC_W-1)'(top);
      d[0]   <= in_det;
      lo[0]  <= in_num[Q_W-1:0];
      q[0]   <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [ACC_W-1:0] trial;
    logic [ACC_W-1:0] diff;
    logic             take;

    assign trial = {r[s], lo[s][Q_W-1-s]};
    assign diff  = trial - {1'b0, d[s]};
    assign take  = (trial >= {1'b0, d[s]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        h[s+1]   <= h[s];
        sat[s+1] <= sat[s];
        r[s+1]   <= take ? diff[ACC_W-2:0] : trial[ACC_W-2:0];
        d[s+1]   <= d[s];
        lo[s+1]  <= lo[s];
        q[s+1]   <= q[s] | (Q_W'(take) << (Q_W-1-s));
      end
    end
  end

  // result selection: miss reads zero, far hit saturates
  assign out_valid    = v[Q_W];
  assign out_hit      = h[Q_W];
  assign out_distance = !h[Q_W] ? 32'd0 :
                        sat[Q_W] ? DIST_SAT : {1'b0, q[Q_W]};

  a_sat_only_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_distance == DIST_SAT && out_distance != 32'd0 |-> out_hit)
    else $error("saturated distance without a hit");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid) && $stable(out_distance))
    else $error("divider moved while stalled");
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("divider valid not cleared by reset");

endmodule

@@ hdl/ray_triangle_intersect.sv @@
// ray/triangle intersection top level: register file, geometry pipeline, hit test
`timescale 1ns / 1ps

//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  in       | in_valid / in_ready        | vert_{a,b,c}_{x,y,z}, signed Q8.8
//  out      | out_valid / out_ready      | hit, distance (signed Q16.16)
//  config   | psel penable pwrite pready | paddr, pwdata, prdata (64 bit)
//
// one triangle per cycle when not stalled; six geometry and hit stages,
// then the divider: a saturation stage and 31 stages of one quotient bit each.
// the whole pipeline advances together; a stalled output freezes every stage.
// reset is synchronous and clears the valid bits and the register file.

module ray_triangle_intersect
  import rtri_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] vert_a_x,
  input  logic signed [COORD_WIDTH-1:0] vert_a_y,
  input  logic signed [COORD_WIDTH-1:0] vert_a_z,
  input  logic signed [COORD_WIDTH-1:0] vert_b_x,
  input  logic signed [COORD_WIDTH-1:0] vert_b_y,
  input  logic signed [COORD_WIDTH-1:0] vert_b_z,
  input  logic signed [COORD_WIDTH-1:0] vert_c_x,
  input  logic signed [COORD_WIDTH-1:0] vert_c_y,
  input  logic signed [COORD_WIDTH-1:0] vert_c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic signed [31:0]            distance,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  logic signed [COORD_WIDTH-1:0] org [3];
  logic signed [COORD_WIDTH-1:0] dir [3];
  logic [THR_W-1:0]              det_threshold;
  logic [IDX_W-1:0]              idx;
  logic                          en;

  // register file
  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= '0;
      det_threshold <= DET_THR_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ORIGIN_X: org[0] <= pwdata[COORD_WIDTH-1:0];
        REG_ORIGIN_Y: org[1] <= pwdata[COORD_WIDTH-1:0];
        REG_ORIGIN_Z: org[2] <= pwdata[COORD_WIDTH-1:0];
        REG_DIR_X:    dir[0] <= pwdata[COORD_WIDTH-1:0];
        REG_DIR_Y:    dir[1] <= pwdata[COORD_WIDTH-1:0];
        REG_DIR_Z:    dir[2] <= pwdata[COORD_WIDTH-1:0];
        REG_DET_THR:  det_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_ORIGIN_X: prdata = DATA_W'($unsigned(org[0]));
      REG_ORIGIN_Y: prdata = DATA_W'($unsigned(org[1]));
      REG_ORIGIN_Z: prdata = DATA_W'($unsigned(org[2]));
      REG_DIR_X:    prdata = DATA_W'($unsigned(dir[0]));
      REG_DIR_Y:    prdata = DATA_W'($unsigned(dir[1]));
      REG_DIR_Z:    prdata = DATA_W'($unsigned(dir[2]));
      REG_DET_THR:  prdata = DATA_W'(det_threshold);
      default:      prdata = '0;
    endcase
  end

  // whole pipeline moves when the output beat is empty or taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic signed [COORD_WIDTH-1:0] va [3];
  logic signed [COORD_WIDTH-1:0] vb [3];
  logic signed [COORD_WIDTH-1:0] vc [3];
  assign va = '{vert_a_x, vert_a_y, vert_a_z};
  assign vb = '{vert_b_x, vert_b_y, vert_b_z};
  assign vc = '{vert_c_x, vert_c_y, vert_c_z};

  logic v1, v2, v3, v4, v5, v6;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  logic signed [EW-1:0]              e1_1 [3], e2_1 [3], ao_1 [3];
  logic signed [EW-1:0]              e1_2 [3], e2_2 [3], ao_2 [3];
  logic signed [EW-1:0]              e1_3 [3], e2_3 [3], ao_3 [3];
  logic signed [2*EW-1:0]            pna [3], pnb [3];
  logic signed [EW+COORD_WIDTH-1:0]  pda [3], pdb [3];
  logic signed [NW-1:0]              nrm [3];
  logic signed [DAO_W-1:0]           dao [3];
  logic signed [COORD_WIDTH+NW-1:0]  pdet [3];
  logic signed [EW+DAO_W-1:0]        pu [3], pv [3];
  logic signed [EW+NW-1:0]           pt [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      if (en) begin
        // stage 1: edges and origin offset
        e1_1[i] <= EW'(vb[i]) - EW'(va[i]);
        e2_1[i] <= EW'(vc[i]) - EW'(va[i]);
        ao_1[i] <= EW'(org[i]) - EW'(va[i]);
        // stage 2: cross product partial products
        pna[i]  <= e1_1[J] * e2_1[K];
        pnb[i]  <= e1_1[K] * e2_1[J];
        pda[i]  <= ao_1[J] * dir[K];
        pdb[i]  <= ao_1[K] * dir[J];
        e1_2[i] <= e1_1[i];
        e2_2[i] <= e2_1[i];
        ao_2[i] <= ao_1[i];
        // stage 3: normal and offset cross direction
        nrm[i]  <= NW'(pna[i]) - NW'(pnb[i]);
        dao[i]  <= DAO_W'(pda[i]) - DAO_W'(pdb[i]);
        e1_3[i] <= e1_2[i];
        e2_3[i] <= e2_2[i];
        ao_3[i] <= ao_2[i];
        // stage 4: dot product terms
        pdet[i] <= dir[i] * nrm[i];
        pu[i]   <= e2_3[i] * dao[i];
        pv[i]   <= e1_3[i] * dao[i];
        pt[i]   <= ao_3[i] * nrm[i];
      end
    end
  end

  logic signed [ACC_W-1:0] det5, un5, vn5, tn5;

  // stage 5: dot product sums
  always_ff @(posedge clk) begin
    if (en) begin
      det5 <= -(ACC_W'(pdet[0]) + ACC_W'(pdet[1]) + ACC_W'(pdet[2]));
      un5  <=   ACC_W'(pu[0])   + ACC_W'(pu[1])   + ACC_W'(pu[2]);
      vn5  <= -(ACC_W'(pv[0])   + ACC_W'(pv[1])   + ACC_W'(pv[2]));
      tn5  <=   ACC_W'(pt[0])   + ACC_W'(pt[1])   + ACC_W'(pt[2]);
    end
  end

  logic signed [ACC_W:0]  uv5;
  logic                   hit5;
  logic                   hit6;
  logic [NUM_W-1:0]       num6;
  logic [ACC_W-2:0]       det6;

  // stage 6: front-face hit test, scaled by det
  assign uv5  = (ACC_W+1)'(un5) + (ACC_W+1)'(vn5);
  assign hit5 = !det5[ACC_W-1] && (det5 != '0)
             && (CMP_W'($unsigned(det5)) >= CMP_W'(det_threshold))
             && !tn5[ACC_W-1] && !un5[ACC_W-1] && !vn5[ACC_W-1]
             && (uv5 <= (ACC_W+1)'(det5));

  always_ff @(posedge clk) begin
    if (en) begin
      hit6 <= hit5;
      num6 <= {tn5[ACC_W-2:0], FRAC_W'(0)};
      det6 <= det5[ACC_W-2:0];
    end
  end

  logic        div_hit;
  logic [31:0] div_dist;

  rtri_div u_div (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (v6),
    .in_hit       (hit6),
    .in_num       (num6),
    .in_det       (det6),
    .out_valid    (out_valid),
    .out_hit      (div_hit),
    .out_distance (div_dist)
  );

  assign hit      = div_hit;
  assign distance = div_dist;

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> distance == 32'sd0)
    else $error("miss with nonzero distance");
  a_hit_nonneg: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !distance[31])
    else $error("negative distance on a hit");
  a_zero_det: assert property (@(posedge clk) disable iff (rst)
    det5 == '0 |-> !hit5)
    else $error("zero determinant taken as a hit");

endmodule
